// ----- sv/dvt_pkg.sv -----
// Shared types and constants for the device record tokenizer.
// No dependencies; the parser, core and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package dvt_pkg;

    localparam int TYPE_LEN    = 16;
    localparam int NAME_LEN    = 32;
    localparam int PNAME_LEN   = 32;
    localparam int VALUE_LEN   = 64;
    localparam int MAX_DEVICES = 8;

    localparam int TYPE_IDX_W   = $clog2(TYPE_LEN);
    localparam int MAX_RESULTS  = 3;
    localparam int KIND_COUNT   = 5;
    localparam int KIND_MAX_LEN = 13;

    localparam logic [7:0] ETX_BYTE   = 8'h03;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] DEL_BYTE   = 8'h7f;
    localparam logic [7:0] SEMI_BYTE  = 8'h3b;
    localparam logic [7:0] EQ_BYTE    = 8'h3d;

    // parse phase codes
    localparam logic [2:0] PH_TYPE  = 3'd0;
    localparam logic [2:0] PH_SKIP  = 3'd1;
    localparam logic [2:0] PH_NAME  = 3'd2;
    localparam logic [2:0] PH_PNAME = 3'd3;
    localparam logic [2:0] PH_VALUE = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;
    localparam logic [2:0] PH_END   = 3'd6;

    // event codes
    localparam logic [3:0] EV_NAME_CHAR  = 4'd0;
    localparam logic [3:0] EV_PNAME_CHAR = 4'd1;
    localparam logic [3:0] EV_VALUE_CHAR = 4'd2;
    localparam logic [3:0] EV_DEV_START  = 4'd3;
    localparam logic [3:0] EV_NAME_END   = 4'd4;
    localparam logic [3:0] EV_PNAME_END  = 4'd5;
    localparam logic [3:0] EV_PARAM_END  = 4'd6;
    localparam logic [3:0] EV_DEV_END    = 4'd7;
    localparam logic [3:0] EV_LIST_END   = 4'd8;
    localparam logic [3:0] EV_ERROR      = 4'd9;
    localparam logic [3:0] EV_SKIPPED    = 4'd10;

    // type names, left-justified and zero padded
    localparam logic [8*KIND_MAX_LEN-1:0] KIND_TEXT [KIND_COUNT] = '{
        {"PRINTER", 48'h0},
        {"RFID", 72'h0},
        {"PAYMENT", 48'h0},
        {"BARCODE", 48'h0},
        "FISCALPRINTER"
    };
    localparam logic [6:0] KIND_LEN [KIND_COUNT] = '{
        7'd7, 7'd4, 7'd7, 7'd7, 7'd13
    };

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] char_out;
        logic [2:0] device_kind;
        logic [3:0] device_number;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                cnt;
    } bundle_t;

endpackage

`default_nettype wire

// ----- sv/dvt_if.sv -----
// Valid/ready channel interfaces for reply bytes and token events.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dvt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       first;

    modport source (output valid, output byte_in, output first, input ready);
    modport sink   (input valid, input byte_in, input first, output ready);
endinterface

interface dvt_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] char_out;
    logic [2:0] device_kind;
    logic [3:0] device_number;
    logic       last;

    modport source (output valid, output event_res, output char_out,
                    output device_kind, output device_number, output last,
                    input ready);
    modport sink   (input valid, input event_res, input char_out,
                    input device_kind, input device_number, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/dvt_parser.sv -----
// Parse state and per-byte tokenizing logic; yields up to three events a byte.
// Depends on dvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvt_parser
    import dvt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] byte_in,
    input  wire logic       first,
    output bundle_t         bundle
);

    logic [2:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic [6:0] cc_reg, cc_next;
    logic [2:0] kind_reg, kind_next;
    logic [3:0] acc_reg, acc_next;
    logic [7:0] type_text_reg [TYPE_LEN];
    logic       type_wr;

    logic [KIND_COUNT-1:0] kind_hit;
    logic [2:0]            hit_code;
    logic                  printable;
    logic [3:0]            left_dec;

    function automatic result_t mk(input logic [3:0] ev, input logic [7:0] ch,
                                   input logic [2:0] kind, input logic [3:0] num);
        result_t r;
        r.event_res     = ev;
        r.char_out      = (ev <= EV_VALUE_CHAR) ? ch : 8'h00;
        r.device_kind   = (ev <= EV_DEV_END) ? kind : 3'd0;
        r.device_number = (ev <= EV_DEV_END) ? num : 4'd0;
        return r;
    endfunction

    always_comb
    begin
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            kind_hit[k] = (cc_reg == KIND_LEN[k]);
            for (int i = 0; i < KIND_MAX_LEN; i++)
            begin
                if (7'(i) < KIND_LEN[k]
                    && type_text_reg[i] != KIND_TEXT[k][8*(KIND_MAX_LEN-1-i) +: 8])
                begin
                    kind_hit[k] = 1'b0;
                end
            end
        end
        hit_code = 3'd0;
        for (int k = KIND_COUNT - 1; k >= 0; k--)
        begin
            if (kind_hit[k])
            begin
                hit_code = 3'(k);
            end
        end
    end

    assign printable = (byte_in > SPACE_BYTE) && (byte_in < DEL_BYTE);
    assign left_dec  = (left_reg != 4'd0) ? left_reg - 4'd1 : left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        cc_next    = cc_reg;
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        type_wr    = 1'b0;
        bundle     = '0;

        if (first)
        begin
            cc_next   = 7'd0;
            acc_next  = 4'd0;
            kind_next = 3'd0;
            if (byte_in == 8'd0 || byte_in > 8'(MAX_DEVICES))
            begin
                left_next  = 4'd0;
                phase_next = PH_ERR;
                bundle.res[bundle.cnt] = mk(EV_ERROR, 8'h00, 3'd0, 4'd0);
                bundle.cnt = bundle.cnt + 2'd1;
            end
            else
            begin
                left_next  = byte_in[3:0];
                phase_next = PH_TYPE;
            end
        end
        else
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    if (byte_in == EQ_BYTE)
                    begin
                        if (kind_hit == '0)
                        begin
                            phase_next = PH_SKIP;
                            bundle.res[bundle.cnt] = mk(EV_SKIPPED, 8'h00, 3'd0, 4'd0);
                            bundle.cnt = bundle.cnt + 2'd1;
                        end
                        else
                        begin
                            kind_next  = hit_code;
                            cc_next    = 7'd0;
                            phase_next = PH_NAME;
                            bundle.res[bundle.cnt] = mk(EV_DEV_START, 8'h00, hit_code,
                                                        acc_reg + 4'd1);
                            bundle.cnt = bundle.cnt + 2'd1;
                        end
                    end
                    else if (printable && cc_reg < 7'(TYPE_LEN))
                    begin
                        type_wr = 1'b1;
                        cc_next = cc_reg + 7'd1;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        bundle.res[bundle.cnt] = mk(EV_ERROR, 8'h00, 3'd0, 4'd0);
                        bundle.cnt = bundle.cnt + 2'd1;
                    end
                end
                PH_SKIP:
                begin
                    if (byte_in == ETX_BYTE)
                    begin
                        left_next = left_dec;
                        if (left_dec == 4'd0)
                        begin
                            phase_next = PH_END;
                            bundle.res[bundle.cnt] = mk(EV_LIST_END, 8'h00, 3'd0, 4'd0);
                            bundle.cnt = bundle.cnt + 2'd1;
                        end
                        else
                        begin
                            cc_next    = 7'd0;
                            phase_next = PH_TYPE;
                        end
                    end
                end
                PH_NAME, PH_VALUE:
                begin
                    if (byte_in == SEMI_BYTE || byte_in == ETX_BYTE)
                    begin
                        bundle.res[bundle.cnt] = mk(
                            (phase_reg == PH_NAME) ? EV_NAME_END : EV_PARAM_END,
                            8'h00, kind_reg, acc_reg + 4'd1);
                        bundle.cnt = bundle.cnt + 2'd1;
                        if (byte_in == SEMI_BYTE)
                        begin
                            cc_next    = 7'd0;
                            phase_next = PH_PNAME;
                        end
                        else
                        begin
                            bundle.res[bundle.cnt] = mk(EV_DEV_END, 8'h00, kind_reg,
                                                        acc_reg + 4'd1);
                            bundle.cnt = bundle.cnt + 2'd1;
                            acc_next  = acc_reg + 4'd1;
                            left_next = left_dec;
                            if (left_dec == 4'd0)
                            begin
                                phase_next = PH_END;
                                bundle.res[bundle.cnt] = mk(EV_LIST_END, 8'h00, 3'd0, 4'd0);
                                bundle.cnt = bundle.cnt + 2'd1;
                            end
                            else
                            begin
                                cc_next    = 7'd0;
                                phase_next = PH_TYPE;
                            end
                        end
                    end
                    else if ((phase_reg == PH_NAME && printable
                              && cc_reg < 7'(NAME_LEN))
                             || (phase_reg == PH_VALUE && byte_in >= SPACE_BYTE
                                 && cc_reg < 7'(VALUE_LEN)))
                    begin
                        cc_next = cc_reg + 7'd1;
                        bundle.res[bundle.cnt] = mk(
                            (phase_reg == PH_NAME) ? EV_NAME_CHAR : EV_VALUE_CHAR,
                            byte_in, kind_reg, acc_reg + 4'd1);
                        bundle.cnt = bundle.cnt + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        bundle.res[bundle.cnt] = mk(EV_ERROR, 8'h00, 3'd0, 4'd0);
                        bundle.cnt = bundle.cnt + 2'd1;
                    end
                end
                PH_PNAME:
                begin
                    if (byte_in == EQ_BYTE)
                    begin
                        cc_next    = 7'd0;
                        phase_next = PH_VALUE;
                        bundle.res[bundle.cnt] = mk(EV_PNAME_END, 8'h00, kind_reg,
                                                    acc_reg + 4'd1);
                        bundle.cnt = bundle.cnt + 2'd1;
                    end
                    else if (printable && cc_reg < 7'(PNAME_LEN))
                    begin
                        cc_next = cc_reg + 7'd1;
                        bundle.res[bundle.cnt] = mk(EV_PNAME_CHAR, byte_in, kind_reg,
                                                    acc_reg + 4'd1);
                        bundle.cnt = bundle.cnt + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        bundle.res[bundle.cnt] = mk(EV_ERROR, 8'h00, 3'd0, 4'd0);
                        bundle.cnt = bundle.cnt + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_END;
            left_reg  <= 4'd0;
            cc_reg    <= 7'd0;
            kind_reg  <= 3'd0;
            acc_reg   <= 4'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            cc_reg    <= cc_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && type_wr)
        begin
            type_text_reg[cc_reg[TYPE_IDX_W-1:0]] <= byte_in;
        end
    end

endmodule

`default_nettype wire

// ----- sv/device_record_tokenizer_core.sv -----
// Top level of the device record tokenizer: input register, parser, event bundle.
// Depends on dvt_pkg, dvt_if.sv and dvt_parser.
//
//  channel     dir  beat carries
//  byte_chan   in   byte_in, first
//  event_chan  out  event_res, char_out, device_kind, device_number, last
//
// A byte is registered, parsed combinationally into a bundle of 0..3 events,
// sent one event per cycle while the sink is ready; the first comes once the
// byte moves on to the bundle register. A byte with n events holds the bundle
// until all n are sent; up to one byte a cycle if each makes at most one event
// and the sink is ready. One further byte waits in the input register while
// the output stalls. Reset leaves the parser ended, awaiting a first byte.
`timescale 1ns / 1ps
`default_nettype none

module device_record_tokenizer_core
    import dvt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dvt_byte_if.sink   byte_chan,
    dvt_event_if.source event_chan
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    bundle_t    parsed;
    bundle_t    bun_reg;
    logic [1:0] idx_reg;

    logic    out_fire;
    logic    out_last;
    logic    bun_free;
    logic    advance;
    logic    in_fire;
    result_t cur;

    assign cur      = bun_reg.res[idx_reg];
    assign out_last = (idx_reg == bun_reg.cnt - 2'd1);
    assign out_fire = event_chan.valid && event_chan.ready;
    assign bun_free = (bun_reg.cnt == 2'd0) || (out_fire && out_last);
    assign advance  = in_valid_reg && bun_free;
    assign in_fire  = byte_chan.valid && byte_chan.ready;

    assign byte_chan.ready = !in_valid_reg || advance;

    assign event_chan.valid         = (bun_reg.cnt != 2'd0);
    assign event_chan.event_res     = cur.event_res;
    assign event_chan.char_out      = cur.char_out;
    assign event_chan.device_kind   = cur.device_kind;
    assign event_chan.device_number = cur.device_number;
    assign event_chan.last          = out_last;

    dvt_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .first   (in_first_reg),
        .bundle  (parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg  <= byte_chan.byte_in;
            in_first_reg <= byte_chan.first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bun_reg <= '0;
            idx_reg <= 2'd0;
        end
        else if (advance)
        begin
            bun_reg <= parsed;
            idx_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            if (out_last)
            begin
                bun_reg.cnt <= 2'd0;
                idx_reg     <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for device_record_tokenizer_core: directed table, then random replies.
// Every event beat is checked, against the directed table's expected beat or a built-in byte tokenizer predictor.
// Depends on dvt_pkg, dvt_if.sv and the core RTL.
`timescale 1ns / 1ps

module tb;
    import dvt_pkg::*;

    localparam int RANDOM_ITEMS  = 410;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [2:0] KIND_RFID    = 3'd1;

    typedef struct packed {
        result_t res;
        logic    last;
    } event_beat_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        typed;
        logic        has_beat;
        event_beat_t beat;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } reply_byte_t;

    localparam event_beat_t NO_BEAT    = '0;
    localparam event_beat_t ERROR_BEAT = '{'{EV_ERROR, 8'h00, 3'd0, 4'd0}, 1'b1};

    localparam int DIRECTED_ROWS = 27;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h41, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b1, 1'b1, ERROR_BEAT},
        '{8'h58, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h09, 1'b1, 1'b1, 1'b1, ERROR_BEAT},
        '{8'hff, 1'b1, 1'b1, 1'b1, ERROR_BEAT},
        '{8'h01, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{8'h52, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h46, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h49, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h44, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{EQ_BYTE, 1'b0, 1'b1, 1'b1, '{'{EV_DEV_START, 8'h00, KIND_RFID, 4'd1}, 1'b1}},
        '{8'h21, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{8'h7e, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{SEMI_BYTE, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{8'h70, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{EQ_BYTE, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{SPACE_BYTE, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ETX_BYTE, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{8'h71, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h01, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{8'h5a, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{EQ_BYTE, 1'b0, 1'b1, 1'b1, '{'{EV_SKIPPED, 8'h00, 3'd0, 4'd0}, 1'b1}},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{ETX_BYTE, 1'b0, 1'b1, 1'b1, '{'{EV_LIST_END, 8'h00, 3'd0, 4'd0}, 1'b1}},
        '{8'h01, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{DEL_BYTE, 1'b0, 1'b1, 1'b1, ERROR_BEAT}
    };

    logic clk;
    logic rst_n;

    dvt_byte_if  byte_chan ();
    dvt_event_if event_chan ();

    device_record_tokenizer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .event_chan (event_chan)
    );

    // predictor state
    logic [2:0] phase_q;
    logic [3:0] left_q;
    logic [6:0] count_q;
    logic [7:0] type_q [TYPE_LEN];
    logic [2:0] kind_q;
    logic [3:0] accepted_q;

    event_beat_t byte_events [$];
    event_beat_t pending_events [$];
    reply_byte_t reply_bytes [$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  calm        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** device_record_tokenizer_core: FAILED **");
            $finish;
        end
    end

    function automatic void post_event(input logic [3:0] ev, input logic [7:0] ch);
        event_beat_t t;
        t.res.event_res     = ev;
        t.res.char_out      = (ev <= EV_VALUE_CHAR) ? ch : 8'h00;
        t.res.device_kind   = (ev <= EV_DEV_END) ? kind_q : 3'd0;
        t.res.device_number = (ev <= EV_DEV_END) ? 4'(accepted_q + 4'd1) : 4'd0;
        t.last              = 1'b0;
        byte_events.push_back(t);
    endfunction

    function automatic void raise_error();
        phase_q = PH_ERR;
        post_event(EV_ERROR, 8'h00);
    endfunction

    function automatic void close_record();
        if (left_q != 4'd0)
            left_q = left_q - 4'd1;
        if (left_q == 4'd0)
        begin
            phase_q = PH_END;
            post_event(EV_LIST_END, 8'h00);
        end
        else
        begin
            count_q = 7'd0;
            phase_q = PH_TYPE;
        end
    endfunction

    function automatic void close_device();
        post_event(EV_DEV_END, 8'h00);
        accepted_q = accepted_q + 4'd1;
        close_record();
    endfunction

    function automatic int match_kind();
        bit same;
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            if (count_q == KIND_LEN[k])
            begin
                same = 1'b1;
                for (int i = 0; i < KIND_LEN[k]; i++)
                    if (type_q[i] != KIND_TEXT[k][8*KIND_MAX_LEN-1-8*i -: 8])
                        same = 1'b0;
                if (same)
                    return k;
            end
        end
        return -1;
    endfunction

    function automatic bit printable(input logic [7:0] b);
        return b > SPACE_BYTE && b < DEL_BYTE;
    endfunction

    // works out the event beats one accepted byte causes
    function automatic void tokenize_byte(input logic [7:0] b, input logic f);
        int k;
        byte_events.delete();
        if (f)
        begin
            count_q    = 7'd0;
            accepted_q = 4'd0;
            kind_q     = 3'd0;
            if (b == 8'd0 || b > MAX_DEVICES)
            begin
                left_q = 4'd0;
                raise_error();
            end
            else
            begin
                left_q  = b[3:0];
                phase_q = PH_TYPE;
            end
        end
        else
        begin
            case (phase_q)
                PH_TYPE:
                begin
                    if (b == EQ_BYTE)
                    begin
                        k = match_kind();
                        if (k < 0)
                        begin
                            phase_q = PH_SKIP;
                            post_event(EV_SKIPPED, 8'h00);
                        end
                        else
                        begin
                            kind_q  = k[2:0];
                            count_q = 7'd0;
                            phase_q = PH_NAME;
                            post_event(EV_DEV_START, 8'h00);
                        end
                    end
                    else if (printable(b) && count_q < TYPE_LEN)
                    begin
                        type_q[count_q[TYPE_IDX_W-1:0]] = b;
                        count_q = count_q + 7'd1;
                    end
                    else
                        raise_error();
                end
                PH_SKIP:
                begin
                    if (b == ETX_BYTE)
                        close_record();
                end
                PH_NAME:
                begin
                    if (b == SEMI_BYTE || b == ETX_BYTE)
                    begin
                        post_event(EV_NAME_END, 8'h00);
                        if (b == SEMI_BYTE)
                        begin
                            count_q = 7'd0;
                            phase_q = PH_PNAME;
                        end
                        else
                            close_device();
                    end
                    else if (printable(b) && count_q < NAME_LEN)
                    begin
                        count_q = count_q + 7'd1;
                        post_event(EV_NAME_CHAR, b);
                    end
                    else
                        raise_error();
                end
                PH_PNAME:
                begin
                    if (b == EQ_BYTE)
                    begin
                        count_q = 7'd0;
                        phase_q = PH_VALUE;
                        post_event(EV_PNAME_END, 8'h00);
                    end
                    else if (printable(b) && count_q < PNAME_LEN)
                    begin
                        count_q = count_q + 7'd1;
                        post_event(EV_PNAME_CHAR, b);
                    end
                    else
                        raise_error();
                end
                PH_VALUE:
                begin
                    if (b == SEMI_BYTE || b == ETX_BYTE)
                    begin
                        post_event(EV_PARAM_END, 8'h00);
                        if (b == SEMI_BYTE)
                        begin
                            count_q = 7'd0;
                            phase_q = PH_PNAME;
                        end
                        else
                            close_device();
                    end
                    else if (b >= SPACE_BYTE && count_q < VALUE_LEN)
                    begin
                        count_q = count_q + 7'd1;
                        post_event(EV_VALUE_CHAR, b);
                    end
                    else
                        raise_error();
                end
                default: ;
            endcase
        end
        if (byte_events.size() > 0)
            byte_events[byte_events.size()-1].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_char(input int lo, input int hi, input logic [7:0] avoid);
        logic [7:0] c;
        do
            c = 8'($urandom_range(hi, lo));
        while (c == avoid);
        return c;
    endfunction

    // mostly short fields, now and then one just under, at or just past its limit
    function automatic int pick_len(input int limit);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(limit - 1, limit + 1);
        return $urandom_range(0, 4);
    endfunction

    function automatic void put_byte(input logic [7:0] data, input logic f);
        reply_bytes.push_back('{data, f});
    endfunction

    function automatic void build_record();
        int r;
        int k;
        int n;
        r = $urandom_range(0, 19);
        if (r < 16)
        begin
            k = $urandom_range(0, KIND_COUNT - 1);
            for (int i = 0; i < KIND_LEN[k]; i++)
                put_byte(KIND_TEXT[k][8*KIND_MAX_LEN-1-8*i -: 8], 1'b0);
            put_byte(EQ_BYTE, 1'b0);
            n = pick_len(NAME_LEN);
            for (int i = 0; i < n; i++)
                put_byte(pick_char(8'h21, 8'h7e, SEMI_BYTE), 1'b0);
            for (int p = $urandom_range(0, 2); p > 0; p--)
            begin
                put_byte(SEMI_BYTE, 1'b0);
                n = pick_len(PNAME_LEN);
                for (int i = 0; i < n; i++)
                    put_byte(pick_char(8'h21, 8'h7e, EQ_BYTE), 1'b0);
                put_byte(EQ_BYTE, 1'b0);
                n = pick_len(VALUE_LEN);
                for (int i = 0; i < n; i++)
                    put_byte(pick_char(8'h20, 8'hff, SEMI_BYTE), 1'b0);
            end
        end
        else
        begin
            // unknown type, or one near or past the type buffer's size
            n = (r < 19) ? $urandom_range(1, 6) : $urandom_range(TYPE_LEN - 1, TYPE_LEN + 2);
            for (int i = 0; i < n; i++)
                put_byte(pick_char(8'h21, 8'h7e, EQ_BYTE), 1'b0);
            put_byte(EQ_BYTE, 1'b0);
            for (int i = $urandom_range(0, 4); i > 0; i--)
                put_byte(pick_char(8'h00, 8'hff, ETX_BYTE), 1'b0);
        end
        put_byte(ETX_BYTE, 1'b0);
    endfunction

    // fills reply_bytes; returns the number of bytes that belong to the reply proper
    function automatic int build_reply();
        int r;
        int devices;
        int useful;
        reply_bytes.delete();
        r = $urandom_range(0, 19);
        if (r == 0)
            devices = 0;
        else if (r == 1)
            devices = $urandom_range(MAX_DEVICES + 1, 255);
        else if (r == 2)
            devices = MAX_DEVICES;
        else
            devices = $urandom_range(1, 3);
        put_byte(8'(devices), 1'b1);
        if (devices >= 1 && devices <= MAX_DEVICES)
            for (int d = 0; d < devices; d++)
                build_record();
        else
            for (int i = $urandom_range(0, 3); i > 0; i--)
                put_byte(pick_char(8'h00, 8'hff, 8'h00), 1'b0);
        r = $urandom_range(0, 19);
        if (r < 2 && reply_bytes.size() > 1)
            reply_bytes[$urandom_range(1, reply_bytes.size() - 1)].data = 8'($urandom_range(0, 255));
        else if (r == 2 && reply_bytes.size() > 1)
            reply_bytes = reply_bytes[0:$urandom_range(1, reply_bytes.size() - 1) - 1];
        useful = reply_bytes.size();
        if ($urandom_range(0, 7) == 0)
            for (int i = $urandom_range(1, 3); i > 0; i--)
                put_byte(8'($urandom_range(0, 255)), 1'b0);
        return useful;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic f, input bit keep);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.valid   <= 1'b1;
        byte_chan.byte_in <= data;
        byte_chan.first   <= f;
        do
            @(posedge clk);
        while (!byte_chan.ready);
        tokenize_byte(data, f);
        if (keep)
            foreach (byte_events[i])
                pending_events.push_back(byte_events[i]);
    endtask

    task automatic wait_drained();
        byte_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
    endtask

    task automatic check_beat(input event_beat_t got);
        event_beat_t want;
        if (pending_events.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected beat ev=%0d ch=%h kind=%0d num=%0d last=%b", $time,
                     got.res.event_res, got.res.char_out, got.res.device_kind,
                     got.res.device_number, got.last);
        end
        else
        begin
            want = pending_events.pop_front();
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: expected ev=%0d ch=%h kind=%0d num=%0d last=%b", $time,
                         want.res.event_res, want.res.char_out, want.res.device_kind,
                         want.res.device_number, want.last);
                $display("%0t:   actual ev=%0d ch=%h kind=%0d num=%0d last=%b", $time,
                         got.res.event_res, got.res.char_out, got.res.device_kind,
                         got.res.device_number, got.last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && event_chan.valid && event_chan.ready)
            check_beat({event_chan.event_res, event_chan.char_out, event_chan.device_kind,
                        event_chan.device_number, event_chan.last});
    end

    // sink side: random back-pressure, held off during calm stretches
    initial
    begin
        int run;
        event_chan.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            event_chan.ready <= 1'b1;
            if (calm)
                @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 20)) @(posedge clk);
                run = pick_gap();
                if (run > 0)
                begin
                    event_chan.ready <= 1'b0;
                    repeat (run) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int sent;
        int useful;
        phase_q    = PH_END;
        left_q     = 4'd0;
        count_q    = 7'd0;
        kind_q     = 3'd0;
        accepted_q = 4'd0;
        sent       = 0;
        byte_chan.valid   <= 1'b0;
        byte_chan.byte_in <= 8'h00;
        byte_chan.first   <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_byte(DIRECTED[i].data, DIRECTED[i].first, !DIRECTED[i].typed);
            if (DIRECTED[i].typed && DIRECTED[i].has_beat)
                pending_events.push_back(DIRECTED[i].beat);
        end
        wait_drained();

        while (sent < RANDOM_ITEMS)
        begin
            calm   = ($urandom_range(0, 4) == 0);
            useful = build_reply();
            foreach (reply_bytes[i])
                send_byte(reply_bytes[i].data, reply_bytes[i].first, 1'b1);
            sent += useful;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        calm = 1'b0;

        byte_chan.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** device_record_tokenizer_core: PASSED **");
        else
            $display("** device_record_tokenizer_core: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
sv/dvt_pkg.sv
sv/dvt_if.sv
sv/dvt_parser.sv
sv/device_record_tokenizer_core.sv
sim/tb.sv
